[src/hgsv_pkg.sv]
`timescale 1ns / 1ps

package hgsv_pkg;

	localparam int AMP_W = 32;
	localparam int POS_W = 12;
	localparam int CFG_W = 4;

	// round(2^30 / sqrt(2)), Q0.30
	localparam logic signed [30:0] INV_SQRT2_Q30 = 31'sd759250125;
	localparam logic signed [63:0] ROUND_HALF = 64'sd536870912;
	localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
	localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

	typedef enum logic {
		KIND_PASS,
		KIND_PAIR
	} kind_t;

	typedef struct packed {
		logic signed [AMP_W-1:0] amp;
		kind_t                   kind;
		logic [POS_W-1:0]        pos;
		logic [POS_W-1:0]        partner_pos;
		logic                    last;
	} item_t;

endpackage

[src/hgsv_in_if.sv]
`timescale 1ns / 1ps

interface hgsv_in_if;
	logic                    valid;
	logic                    ready;
	logic signed [31:0]      amplitude;
	logic                    last_of_vector;

	modport source(output valid, amplitude, last_of_vector, input ready);
	modport sink(input valid, amplitude, last_of_vector, output ready);
endinterface

[src/hgsv_out_if.sv]
`timescale 1ns / 1ps

interface hgsv_out_if;
	logic               valid;
	logic               ready;
	logic [11:0]        position;
	logic signed [31:0] result_amplitude;
	logic               end_of_pair;
	logic               end_of_vector;

	modport source(output valid, position, result_amplitude, end_of_pair, end_of_vector,
		input ready);
	modport sink(input valid, position, result_amplitude, end_of_pair, end_of_vector,
		output ready);
endinterface

[src/hgsv_cfg_if.sv]
`timescale 1ns / 1ps

interface hgsv_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

[src/hgsv_front.sv]
`timescale 1ns / 1ps

module hgsv_front #(
	parameter int STATE_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	hgsv_in_if.sink                           stream,
	input  logic [hgsv_pkg::CFG_W-1:0]        target,
	input  logic                              done,
	output hgsv_pkg::item_t                   item_s1,
	output logic                              valid_s1,
	output logic signed [hgsv_pkg::AMP_W-1:0] partner_q
);

	localparam int ADDR_W = (STATE_BITS > 1) ? STATE_BITS - 1 : 1;
	localparam int DEPTH = 1 << (STATE_BITS - 1);
	localparam logic [4:0] SB_V = 5'(STATE_BITS);

	logic [STATE_BITS-1:0]             pos_q;
	logic signed [hgsv_pkg::AMP_W-1:0] buf_mem [DEPTH];

	logic                  acc;
	logic                  bypass;
	logic                  is_high;
	logic [STATE_BITS-1:0] z;
	logic [STATE_BITS-1:0] lowmask;
	logic [STATE_BITS-1:0] upper;
	logic [STATE_BITS-1:0] addr_full;
	logic [ADDR_W-1:0]     addr;
	logic                  produce;
	hgsv_pkg::item_t       item_d;

	assign stream.ready = !valid_s1 || done;
	assign acc = stream.valid && stream.ready;

	always_comb begin
		bypass = {1'b0, target} >= SB_V;
		z = STATE_BITS'(1) << target;
		lowmask = z - STATE_BITS'(1);
		upper = (pos_q >> ({1'b0, target} + 5'd1)) << target;
		addr_full = (pos_q & lowmask) | upper;
		addr = addr_full[ADDR_W-1:0];
		is_high = !bypass && (|(pos_q & z));
		produce = bypass || is_high || stream.last_of_vector;
		item_d.amp = stream.amplitude;
		item_d.kind = is_high ? hgsv_pkg::KIND_PAIR : hgsv_pkg::KIND_PASS;
		item_d.pos = hgsv_pkg::POS_W'(pos_q);
		item_d.partner_pos = hgsv_pkg::POS_W'(pos_q ^ z);
		item_d.last = stream.last_of_vector;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (acc) begin
				pos_q <= stream.last_of_vector ? '0 : pos_q + STATE_BITS'(1);
				valid_s1 <= produce;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1 <= item_d;
		end
	end

	// partner buffer: low half written, high half reads its partner
	always_ff @(posedge clk) begin
		if (acc && !bypass) begin
			if (is_high) begin
				partner_q <= buf_mem[addr];
			end else begin
				buf_mem[addr] <= stream.amplitude;
			end
		end
	end

endmodule

[src/hgsv_butterfly.sv]
`timescale 1ns / 1ps

module hgsv_butterfly (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hgsv_pkg::item_t                   item_s1,
	input  logic                              valid_s1,
	input  logic signed [hgsv_pkg::AMP_W-1:0] partner_q,
	output logic                              done,
	hgsv_out_if.source                        result
);

	logic valid_q;
	logic hold_q;
	logic out_free;
	logic load;
	logic is_pair;

	logic [hgsv_pkg::POS_W-1:0]        hold_pos_q;
	logic signed [hgsv_pkg::AMP_W-1:0] hold_amp_q;
	logic                              hold_last_q;

	logic signed [32:0] sum;
	logic signed [32:0] diff;
	logic signed [31:0] scaled_sum;
	logic signed [31:0] scaled_diff;

	// c * s, rounded half up, saturated to 32 bits
	function automatic logic signed [31:0] scale_sat(input logic signed [32:0] s);
		logic signed [63:0] prod;
		logic signed [63:0] rnd;
		logic signed [33:0] q;
		prod = 64'(s) * 64'(hgsv_pkg::INV_SQRT2_Q30);
		rnd = (prod + hgsv_pkg::ROUND_HALF) >>> 30;
		q = rnd[33:0];
		if (q > hgsv_pkg::SAT_MAX) begin
			return 32'sh7fffffff;
		end else if (q < hgsv_pkg::SAT_MIN) begin
			return 32'sh80000000;
		end else begin
			return q[31:0];
		end
	endfunction

	assign out_free = !valid_q || result.ready;
	assign load = valid_s1 && !hold_q && out_free;
	assign done = load;
	assign result.valid = valid_q;

	// sum goes out first, difference waits in the hold register
	always_comb begin
		is_pair = item_s1.kind == hgsv_pkg::KIND_PAIR;
		sum = 33'(partner_q) + 33'(item_s1.amp);
		diff = 33'(partner_q) - 33'(item_s1.amp);
		scaled_sum = scale_sat(sum);
		scaled_diff = scale_sat(diff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hold_q <= 1'b0;
		end else begin
			if (hold_q && out_free) begin
				valid_q <= 1'b1;
				hold_q <= 1'b0;
			end else if (load) begin
				valid_q <= 1'b1;
				hold_q <= is_pair;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hold_q && out_free) begin
			result.position <= hold_pos_q;
			result.result_amplitude <= hold_amp_q;
			result.end_of_pair <= 1'b1;
			result.end_of_vector <= hold_last_q;
		end else if (load) begin
			if (!is_pair) begin
				result.position <= item_s1.pos;
				result.result_amplitude <= item_s1.amp;
				result.end_of_pair <= 1'b1;
				result.end_of_vector <= item_s1.last;
			end else begin
				result.position <= item_s1.partner_pos;
				result.result_amplitude <= scaled_sum;
				result.end_of_pair <= 1'b0;
				result.end_of_vector <= 1'b0;
				hold_pos_q <= item_s1.pos;
				hold_amp_q <= scaled_diff;
				hold_last_q <= item_s1.last;
			end
		end
	end

endmodule

[src/hadamard_gate_state_vector_top.sv]
`timescale 1ns / 1ps

// Streaming Hadamard gate on one qubit of a real Q1.30 state vector.
// stream: one amplitude per request, in index order; last_of_vector ends a
//   vector and clears the position counter.
// result: position, scaled amplitude, end_of_pair, end_of_vector. A pair is
//   given when the amplitude with the target bit set arrives: low index first.
// cfg: target qubit, always ready; write it only while the block is idle.
// A request is registered in the input stage, then in the output register.
// Throughput: one request per cycle unless the output stalls or a held result
//   blocks. Both results of a pair are formed at once; the second waits in a
//   hold register, which blocks the next request that gives results. With
//   target 0 or out of range the hold register does not slow a vector; with a
//   higher target it slows the high-half requests.
// Reset clears the position counter, target (0) and all valid flags; the
//   partner buffer is not cleared and needs no clearing pass.
// A stalled result receiver holds the output and hold registers; low-half
//   requests still enter, one request that gives results is taken into the
//   input stage, then stream.ready drops.
module hadamard_gate_state_vector_top #(
	parameter int STATE_BITS = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	hgsv_in_if.sink    stream,
	hgsv_out_if.source result,
	hgsv_cfg_if.sink   cfg
);

	logic [hgsv_pkg::CFG_W-1:0]        target_q;
	hgsv_pkg::item_t                   item_s1;
	logic                              valid_s1;
	logic                              done;
	logic signed [hgsv_pkg::AMP_W-1:0] partner_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg.valid) begin
			target_q <= cfg.data;
		end
	end

	hgsv_front #(
		.STATE_BITS(STATE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.target   (target_q),
		.done     (done),
		.item_s1  (item_s1),
		.valid_s1 (valid_s1),
		.partner_q(partner_q)
	);

	hgsv_butterfly u_butterfly (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_s1  (item_s1),
		.valid_s1 (valid_s1),
		.partner_q(partner_q),
		.done     (done),
		.result   (result)
	);

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 250000;
	localparam int RANDOM_ITEMS = 420;
	localparam int SETTLE_CYCLES = 6;
	localparam int DIRECTED_ROWS = 26;

	typedef struct packed {
		logic [hgsv_pkg::POS_W-1:0] position;
		logic [hgsv_pkg::AMP_W-1:0] amplitude;
		logic                       end_of_pair;
		logic                       end_of_vector;
	} amp_result_t;

	typedef enum logic {
		ROW_TARGET,
		ROW_AMP
	} row_kind_t;

	typedef struct packed {
		row_kind_t                  kind;
		logic [hgsv_pkg::AMP_W-1:0] value;
		logic                       last;
		logic                       typed;
		logic [1:0]                 n;
		amp_result_t                r0;
		amp_result_t                r1;
	} stim_row_t;

	localparam amp_result_t NO_RES = '0;

	// typed rows carry their results; the rest go through the predictor
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{ROW_AMP, 32'h7FFFFFFF, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
		'{ROW_AMP, 32'h7FFFFFFF, 1'b0, 1'b1, 2'd2,
			'{12'd0, 32'h7FFFFFFF, 1'b0, 1'b0}, '{12'd1, 32'h00000000, 1'b1, 1'b0}},
		'{ROW_AMP, 32'h80000000, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
		'{ROW_AMP, 32'h80000000, 1'b0, 1'b1, 2'd2,
			'{12'd2, 32'h80000000, 1'b0, 1'b0}, '{12'd3, 32'h00000000, 1'b1, 1'b0}},
		'{ROW_AMP, 32'h7FFFFFFF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
		'{ROW_AMP, 32'h80000000, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
		'{ROW_AMP, 32'h80000000, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
		'{ROW_AMP, 32'h7FFFFFFF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
		'{ROW_AMP, 32'h40000000, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
		'{ROW_AMP, 32'h00000000, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
		'{ROW_AMP, 32'h12345678, 1'b1, 1'b1, 2'd1,
			'{12'd10, 32'h12345678, 1'b1, 1'b1}, NO_RES},
		'{ROW_TARGET, 32'd15, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
		'{ROW_AMP, 32'hDEADBEEF, 1'b0, 1'b1, 2'd1,
			'{12'd0, 32'hDEADBEEF, 1'b1, 1'b0}, NO_RES},
		'{ROW_AMP, 32'h80000000, 1'b1, 1'b1, 2'd1,
			'{12'd1, 32'h80000000, 1'b1, 1'b1}, NO_RES},
		'{ROW_TARGET, 32'd1, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
		'{ROW_AMP, 32'hC0000000, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
		'{ROW_AMP, 32'h3FFFFFFF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
		'{ROW_AMP, 32'h00000001, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
		'{ROW_AMP, 32'hFFFFFFFF, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
		'{ROW_TARGET, 32'd0, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
		'{ROW_AMP, 32'h55555555, 1'b1, 1'b1, 2'd1,
			'{12'd0, 32'h55555555, 1'b1, 1'b1}, NO_RES},
		'{ROW_AMP, 32'hAAAAAAAA, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
		'{ROW_AMP, 32'h00000003, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
		'{ROW_AMP, 32'h7FFFFFFF, 1'b1, 1'b1, 2'd1,
			'{12'd0, 32'h7FFFFFFF, 1'b1, 1'b1}, NO_RES},
		'{ROW_TARGET, 32'd12, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
		'{ROW_AMP, 32'h00000000, 1'b1, 1'b1, 2'd1,
			'{12'd0, 32'h00000000, 1'b1, 1'b1}, NO_RES}
	};

	logic clk;
	logic arst_n;
	bit steady = 1'b0;
	int unsigned cycle_count = 0;
	int unsigned mismatch_count = 0;

	logic [hgsv_pkg::CFG_W-1:0] target_qubit = '0;
	logic [hgsv_pkg::POS_W-1:0] next_position = '0;
	logic signed [hgsv_pkg::AMP_W-1:0] held_amp [2048];
	amp_result_t expected_amps [$];

	hgsv_in_if stream_if();
	hgsv_out_if result_if();
	hgsv_cfg_if cfg_if();

	hadamard_gate_state_vector_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream_if),
		.result(result_if),
		.cfg(cfg_if)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_if.ready <= steady || ($urandom_range(99) >= 27);
		end
	end

	function automatic logic [hgsv_pkg::AMP_W-1:0] scale_round_sat(input longint s);
		longint prod;
		longint q;
		prod = s * longint'(hgsv_pkg::INV_SQRT2_Q30);
		q = (prod + 64'sd536870912) >>> 30;
		if (q > 64'sd2147483647)
			q = 64'sd2147483647;
		else if (q < -64'sd2147483648)
			q = -64'sd2147483648;
		return q[hgsv_pkg::AMP_W-1:0];
	endfunction

	function automatic int unsigned hadamard_step(input logic [hgsv_pkg::AMP_W-1:0] amp,
		input logic last, output amp_result_t first, output amp_result_t second);
		logic [hgsv_pkg::POS_W-1:0] pos;
		logic [hgsv_pkg::POS_W-1:0] z;
		logic [hgsv_pkg::POS_W-2:0] addr;
		longint a0;
		longint a1;
		int unsigned n;
		pos = next_position;
		first = '0;
		second = '0;
		n = 0;
		if (target_qubit >= hgsv_pkg::CFG_W'(hgsv_pkg::POS_W)) begin
			first = '{pos, amp, 1'b1, last};
			n = 1;
		end else begin
			z = 12'd1 << target_qubit;
			addr = 11'((pos & (z - 12'd1)) | ((pos >> (target_qubit + 1)) << target_qubit));
			if ((pos & z) != '0) begin
				a0 = longint'(held_amp[addr]);
				a1 = longint'($signed(amp));
				first = '{pos ^ z, scale_round_sat(a0 + a1), 1'b0, 1'b0};
				second = '{pos, scale_round_sat(a0 - a1), 1'b1, last};
				n = 2;
			end else begin
				held_amp[addr] = amp;
				if (last) begin
					first = '{pos, amp, 1'b1, 1'b1};
					n = 1;
				end
			end
		end
		next_position = last ? '0 : pos + 12'd1;
		return n;
	endfunction

	always @(posedge clk) begin
		amp_result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (expected_amps.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: pos %0d amp %h eop %b eov %b",
						result_if.position, result_if.result_amplitude,
						result_if.end_of_pair, result_if.end_of_vector);
			end else begin
				want = expected_amps.pop_front();
				if (result_if.position !== want.position
					|| result_if.result_amplitude !== want.amplitude
					|| result_if.end_of_pair !== want.end_of_pair
					|| result_if.end_of_vector !== want.end_of_vector) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: got %0d %h %b %b, exp %0d %h %b %b",
							result_if.position, result_if.result_amplitude,
							result_if.end_of_pair, result_if.end_of_vector,
							want.position, want.amplitude, want.end_of_pair,
							want.end_of_vector);
				end
			end
		end
	end

	task automatic wait_idle();
		@(negedge clk);
		stream_if.valid <= 1'b0;
		while (expected_amps.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_target(input logic [hgsv_pkg::CFG_W-1:0] value);
		wait_idle();
		cfg_if.valid <= 1'b1;
		cfg_if.data <= value;
		do @(posedge clk); while (!cfg_if.ready);
		target_qubit = value;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic push_amp(input stim_row_t row);
		amp_result_t p0;
		amp_result_t p1;
		int unsigned n;
		@(negedge clk);
		while (!steady && $urandom_range(99) < 27) begin
			stream_if.valid <= 1'b0;
			@(negedge clk);
		end
		stream_if.valid <= 1'b1;
		stream_if.amplitude <= row.value;
		stream_if.last_of_vector <= row.last;
		do @(posedge clk); while (!stream_if.ready);
		n = hadamard_step(row.value, row.last, p0, p1);
		if (row.typed) begin
			n = row.n;
			p0 = row.r0;
			p1 = row.r1;
		end
		if (n > 0)
			expected_amps.push_back(p0);
		if (n > 1)
			expected_amps.push_back(p1);
	endtask

	function automatic logic [hgsv_pkg::AMP_W-1:0] random_amp();
		case ($urandom_range(9))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'($urandom_range(255));
			3: return -32'($urandom_range(255));
			default: return $urandom;
		endcase
	endfunction

	function automatic stim_row_t amp_row(input logic [hgsv_pkg::AMP_W-1:0] amp,
		input logic last);
		stim_row_t row;
		row = '0;
		row.kind = ROW_AMP;
		row.value = amp;
		row.last = last;
		return row;
	endfunction

	initial begin
		int unsigned items_sent;
		int unsigned vec;
		int unsigned len;
		logic [hgsv_pkg::CFG_W-1:0] pick;
		arst_n = 1'b0;
		stream_if.valid = 1'b0;
		stream_if.amplitude = '0;
		stream_if.last_of_vector = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (directed_rows[i].kind == ROW_TARGET)
				write_target(directed_rows[i].value[hgsv_pkg::CFG_W-1:0]);
			else
				push_amp(directed_rows[i]);
		end

		items_sent = 0;
		vec = 0;
		while (items_sent < RANDOM_ITEMS) begin
			steady = (vec >= 10 && vec < 18);
			if (vec == 0 || $urandom_range(2) == 0) begin
				case ($urandom_range(9))
					0: pick = hgsv_pkg::CFG_W'($urandom_range(15, 12));
					1: pick = hgsv_pkg::CFG_W'($urandom_range(11, 6));
					default: pick = hgsv_pkg::CFG_W'($urandom_range(5, 0));
				endcase
				write_target(pick);
			end else if ($urandom_range(7) == 0) begin
				wait_idle();
			end
			// mostly whole power-of-two vectors, some cut short
			if ($urandom_range(3) != 0)
				len = 1 << $urandom_range(($urandom_range(7) == 0) ? 7 : 6, 1);
			else
				len = $urandom_range(48, 1);
			for (int i = 0; i < len; i++)
				push_amp(amp_row(random_amp(), i == len - 1));
			items_sent += len;
			vec++;
		end
		steady = 1'b0;

		wait_idle();
		repeat (10) @(negedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[sim.f]
src/hgsv_pkg.sv
src/hgsv_in_if.sv
src/hgsv_out_if.sv
src/hgsv_cfg_if.sv
src/hgsv_front.sv
src/hgsv_butterfly.sv
src/hadamard_gate_state_vector_top.sv
test/testbench.sv
